### sv/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared widths, register map, reset values and types of the YUYV to RGB
// stream converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

    localparam int BYTE_W  = 8;
    localparam int COEF_W  = 10;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 20;
    localparam int ROW_W   = 12;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 3;

    localparam int LINE_LIMIT       = 4096;
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_FIFO_DEPTH   = 4;

    // Register indexes (byte address is four times the index)
    localparam logic [INDEX_W-1:0] REG_COEF_LUMA    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COEF_RED_V   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_COEF_GREEN_V = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COEF_GREEN_U = 3'd3;
    localparam logic [INDEX_W-1:0] REG_COEF_BLUE_U  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_LINE_WIDTH   = 3'd5;
    localparam logic [INDEX_W-1:0] REG_LINE_COUNT   = 3'd6;

    // Reset values
    localparam logic [COEF_W-1:0] RST_COEF_LUMA    = 10'd299;
    localparam logic [COEF_W-1:0] RST_COEF_RED_V   = 10'd410;
    localparam logic [COEF_W-1:0] RST_COEF_GREEN_V = 10'd208;
    localparam logic [COEF_W-1:0] RST_COEF_GREEN_U = 10'd101;
    localparam logic [COEF_W-1:0] RST_COEF_BLUE_U  = 10'd518;
    localparam logic [DIM_W-1:0]  RST_LINE_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0]  RST_LINE_COUNT   = 13'd480;

    // Offsets removed from the samples
    localparam logic [BYTE_W:0] LUMA_OFFSET   = 9'd16;
    localparam logic [BYTE_W:0] CHROMA_OFFSET = 9'd128;

    typedef struct packed {
        logic [COEF_W-1:0] coef_luma;
        logic [COEF_W-1:0] coef_red_v;
        logic [COEF_W-1:0] coef_green_v;
        logic [COEF_W-1:0] coef_green_u;
        logic [COEF_W-1:0] coef_blue_u;
        logic [DIM_W-1:0]  line_width;
        logic [DIM_W-1:0]  line_count;
    } cfg_t;

    // One macropixel with its line and frame marks
    typedef struct packed {
        logic [BYTE_W-1:0] y0;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] y1;
        logic [BYTE_W-1:0] v;
        logic              eol;
        logic              eof;
    } entry_t;

    // Queue head: valid flag and the entry at the head, from queue to back end
    typedef struct packed {
        logic   valid;
        entry_t data;
    } queue_head_t;

endpackage

### sv/yrgb_regs.sv
// ----------------------------------------------------------------------------
// yrgb_regs
// APB-style configuration registers: conversion gains and frame geometry.
// ----------------------------------------------------------------------------
module yrgb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [yrgb_pkg::ADDR_W-1:0]  paddr,
    input  logic [yrgb_pkg::DATA_W-1:0]  pwdata,
    output logic [yrgb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output yrgb_pkg::cfg_t               cfg
);
    import yrgb_pkg::*;

    cfg_t               cfg_reg;
    logic [INDEX_W-1:0] index;
    logic               wr_en;

    assign pready = 1'b1;
    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write the addressed register; ignore indexes past the map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_luma    <= RST_COEF_LUMA;
            cfg_reg.coef_red_v   <= RST_COEF_RED_V;
            cfg_reg.coef_green_v <= RST_COEF_GREEN_V;
            cfg_reg.coef_green_u <= RST_COEF_GREEN_U;
            cfg_reg.coef_blue_u  <= RST_COEF_BLUE_U;
            cfg_reg.line_width   <= RST_LINE_WIDTH;
            cfg_reg.line_count   <= RST_LINE_COUNT;
        end else if (wr_en) begin
            unique case (index)
                REG_COEF_LUMA:    cfg_reg.coef_luma    <= pwdata[COEF_W-1:0];
                REG_COEF_RED_V:   cfg_reg.coef_red_v   <= pwdata[COEF_W-1:0];
                REG_COEF_GREEN_V: cfg_reg.coef_green_v <= pwdata[COEF_W-1:0];
                REG_COEF_GREEN_U: cfg_reg.coef_green_u <= pwdata[COEF_W-1:0];
                REG_COEF_BLUE_U:  cfg_reg.coef_blue_u  <= pwdata[COEF_W-1:0];
                REG_LINE_WIDTH:   cfg_reg.line_width   <= pwdata[DIM_W-1:0];
                REG_LINE_COUNT:   cfg_reg.line_count   <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (index)
            REG_COEF_LUMA:    prdata = DATA_W'(cfg_reg.coef_luma);
            REG_COEF_RED_V:   prdata = DATA_W'(cfg_reg.coef_red_v);
            REG_COEF_GREEN_V: prdata = DATA_W'(cfg_reg.coef_green_v);
            REG_COEF_GREEN_U: prdata = DATA_W'(cfg_reg.coef_green_u);
            REG_COEF_BLUE_U:  prdata = DATA_W'(cfg_reg.coef_blue_u);
            REG_LINE_WIDTH:   prdata = DATA_W'(cfg_reg.line_width);
            REG_LINE_COUNT:   prdata = DATA_W'(cfg_reg.line_count);
            default:          prdata = '0;
        endcase
    end

endmodule

### sv/yrgb_front.sv
// ----------------------------------------------------------------------------
// yrgb_front
// Byte collector: gathers Y0 U Y1 V, marks line and frame ends and pushes
// one macropixel into the queue on each V byte.
// ----------------------------------------------------------------------------
module yrgb_front #(
    parameter int MAX_WIDTH = yrgb_pkg::DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  yrgb_pkg::cfg_t               cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [yrgb_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                         queue_full,
    output logic                         push,
    output yrgb_pkg::entry_t             push_data
);
    import yrgb_pkg::*;

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);

    localparam logic [1:0] PH_Y0 = 2'd0;
    localparam logic [1:0] PH_U  = 2'd1;
    localparam logic [1:0] PH_Y1 = 2'd2;
    localparam logic [1:0] PH_V  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] y0_reg, u_reg, y1_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              accept;
    logic [31:0]       width_raw, width_clamp;
    logic [EW-1:0]     eff_width, col_plus;
    logic [DIM_W-1:0]  eff_lines, row_plus;
    logic              eol, eof;

    // Take bytes freely except a V byte with no room in the queue
    assign s_ready = (phase_reg != PH_V) || !queue_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (phase_reg == PH_V);

    // Effective geometry: clamp width, force it even; clamp line count
    always_comb begin
        width_raw = 32'(cfg.line_width);
        if (width_raw < 32'd2) begin
            width_clamp = 32'd2;
        end else if (width_raw > 32'(MAX_WIDTH)) begin
            width_clamp = 32'(MAX_WIDTH);
        end else begin
            width_clamp = width_raw;
        end
        eff_width = {width_clamp[EW-1:1], 1'b0};
        if (cfg.line_count == '0) begin
            eff_lines = DIM_W'(1);
        end else if (cfg.line_count > DIM_W'(LINE_LIMIT)) begin
            eff_lines = DIM_W'(LINE_LIMIT);
        end else begin
            eff_lines = cfg.line_count;
        end
    end

    // End of line and frame for the pair that the V byte closes
    assign col_plus = EW'(col_reg) + EW'(2);
    assign row_plus = DIM_W'(row_reg) + DIM_W'(1);
    assign eol      = col_plus >= eff_width;
    assign eof      = eol && (row_plus >= eff_lines);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (eol) begin
            col_next = '0;
            row_next = eof ? '0 : row_plus[ROW_W-1:0];
        end else begin
            col_next = col_plus[CW-1:0];
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_Y0:   phase_next = PH_U;
            PH_U:    phase_next = PH_Y1;
            PH_Y1:   phase_next = PH_V;
            PH_V:    phase_next = PH_Y0;
            default: phase_next = PH_Y0;
        endcase
    end

    assign push_data.y0  = y0_reg;
    assign push_data.u   = u_reg;
    assign push_data.y1  = y1_reg;
    assign push_data.v   = s_data_byte;
    assign push_data.eol = eol;
    assign push_data.eof = eof;

    // Advance phase on each accepted byte and counters on each accepted V byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_Y0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            if (phase_reg == PH_V) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Hold the first three bytes of the macropixel
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (phase_reg == PH_Y0) begin
                y0_reg <= s_data_byte;
            end
            if (phase_reg == PH_U) begin
                u_reg <= s_data_byte;
            end
            if (phase_reg == PH_Y1) begin
                y1_reg <= s_data_byte;
            end
        end
    end

endmodule

### sv/yrgb_fifo.sv
// ----------------------------------------------------------------------------
// yrgb_fifo
// Short macropixel queue between byte collector and pixel pipeline.
// ----------------------------------------------------------------------------
module yrgb_fifo #(
    parameter int DEPTH = yrgb_pkg::DEF_FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  yrgb_pkg::entry_t      push_data,
    output logic                  full,
    input  logic                  pop,
    output yrgb_pkg::queue_head_t head
);
    import yrgb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full       = count_reg == NW'(DEPTH);
    assign head.valid = count_reg != '0;
    assign head.data  = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/yrgb_back.sv
// ----------------------------------------------------------------------------
// yrgb_back
// Pixel pipeline: splits each macropixel into two pixels, multiplies by the
// gains, then sums into the output register.
// ----------------------------------------------------------------------------
module yrgb_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  yrgb_pkg::cfg_t                    cfg,
    input  yrgb_pkg::queue_head_t             head,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_red,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_green,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_blue,
    output logic                              m_pair_last,
    output logic                              m_end_of_line,
    output logic                              m_end_of_frame
);
    import yrgb_pkg::*;

    logic                    sel_reg;
    logic                    a_valid_reg, a_last_reg, a_eol_reg, a_eof_reg;
    logic signed [PIX_W-1:0] luma_reg, rv_reg, gv_reg, gu_reg, bu_reg;
    logic                    b_valid_reg, b_last_reg, b_eol_reg, b_eof_reg;
    logic signed [PIX_W-1:0] red_reg, green_reg, blue_reg;

    logic                    a_en, b_en, load;
    logic [BYTE_W-1:0]       y_sel;
    logic signed [BYTE_W:0]  yo, uo, vo;
    logic signed [PIX_W-1:0] yo_w, uo_w, vo_w;

    // Pipeline enables: output stage frees first, product stage follows
    assign b_en = !b_valid_reg || m_ready;
    assign a_en = !a_valid_reg || b_en;
    assign load = a_en && head.valid;
    assign pop  = load && sel_reg;

    // Offset samples of the selected pixel
    assign y_sel = sel_reg ? head.data.y1 : head.data.y0;
    assign yo    = $signed({1'b0, y_sel})       - $signed(LUMA_OFFSET);
    assign uo    = $signed({1'b0, head.data.u}) - $signed(CHROMA_OFFSET);
    assign vo    = $signed({1'b0, head.data.v}) - $signed(CHROMA_OFFSET);
    assign yo_w  = PIX_W'(yo);
    assign uo_w  = PIX_W'(uo);
    assign vo_w  = PIX_W'(vo);

    // Control of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= head.valid;
                if (head.valid) begin
                    sel_reg <= !sel_reg;
                end
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (load) begin
            luma_reg   <= $signed(PIX_W'(cfg.coef_luma))    * yo_w;
            rv_reg     <= $signed(PIX_W'(cfg.coef_red_v))   * vo_w;
            gv_reg     <= $signed(PIX_W'(cfg.coef_green_v)) * vo_w;
            gu_reg     <= $signed(PIX_W'(cfg.coef_green_u)) * uo_w;
            bu_reg     <= $signed(PIX_W'(cfg.coef_blue_u))  * uo_w;
            a_last_reg <= sel_reg;
            a_eol_reg  <= sel_reg && head.data.eol;
            a_eof_reg  <= sel_reg && head.data.eof;
        end
    end

    // Sum stage into the output register; sums wrap at the field width
    always_ff @(posedge aclk) begin
        if (b_en && a_valid_reg) begin
            red_reg    <= luma_reg + rv_reg;
            green_reg  <= luma_reg - gv_reg - gu_reg;
            blue_reg   <= luma_reg + bu_reg;
            b_last_reg <= a_last_reg;
            b_eol_reg  <= a_eol_reg;
            b_eof_reg  <= a_eof_reg;
        end
    end

    assign m_valid        = b_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_pair_last    = b_last_reg;
    assign m_end_of_line  = b_eol_reg;
    assign m_end_of_frame = b_eof_reg;

    // Line end only on the second pixel of a pair
    a_eol_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_eol_reg |-> b_last_reg)
        else $error("end of line on first pixel of a pair");

    // Frame end only together with a line end
    a_eof_has_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_eof_reg |-> b_eol_reg)
        else $error("end of frame without end of line");

    // A first pixel moving on is followed at once by its partner
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_last_reg && b_en |=> a_valid_reg && a_last_reg)
        else $error("second pixel of a pair did not follow the first");

    // The queue head is popped only while its first pixel sits in the product stage
    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid && a_valid_reg && !a_last_reg)
        else $error("macropixel popped without its first pixel");

endmodule

### sv/yuyv_to_rgb_stream.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_stream
// Packed YUYV 4:2:2 byte stream to signed fixed-point RGB pixel stream.
//
// Input channel (s_*): one byte per transaction, cycling Y0, U, Y1, V.
// Output channel (m_*): one pixel per transaction, red, green and blue in
// signed units of 2^-8, plus pair, end of line and end of frame marks.
// Each V byte yields two pixels: the Y0 pixel, then the Y1 pixel.
// Configuration: APB-style port, registers at byte addresses 0 to 24.
//
// Throughput: one byte per cycle in unless a V byte waits for queue room;
// the pixel pipeline sustains one pixel per cycle while the receiver is ready.
// Path: a macropixel enters the queue on its V byte; each pixel then passes
// the product register and then the output register, the Y0 pixel first.
// Reset: counters and byte phase return to the start of a frame, the queue
// empties and all gains and geometry take their default values.
// Receiver stall: the output register holds its pixel; the queue absorbs
// up to FIFO_DEPTH macropixels, after which V bytes are refused.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_stream #(
    parameter int MAX_WIDTH  = yrgb_pkg::DEF_MAX_WIDTH,
    parameter int FIFO_DEPTH = yrgb_pkg::DEF_FIFO_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yrgb_pkg::ADDR_W-1:0]       paddr,
    input  logic [yrgb_pkg::DATA_W-1:0]       pwdata,
    output logic [yrgb_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [yrgb_pkg::BYTE_W-1:0]       s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_red,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_green,
    output logic signed [yrgb_pkg::PIX_W-1:0] m_blue,
    output logic                              m_pair_last,
    output logic                              m_end_of_line,
    output logic                              m_end_of_frame
);
    import yrgb_pkg::*;

    cfg_t        cfg;
    logic        queue_full, push, pop;
    entry_t      push_data;
    queue_head_t head;

    yrgb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    yrgb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    yrgb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    yrgb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_pair_last    (m_pair_last),
        .m_end_of_line  (m_end_of_line),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule
